/* rtl/tmc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmc_pkg
// Shared types, constants and the sine-table function for the matrix composer.
// ----------------------------------------------------------------------------
package tmc_pkg;

  localparam int ANGLE_BITS    = 12;
  localparam int FRACTION_BITS = 16;
  localparam int DIM           = 4;
  localparam int QUARTER       = 1 << (ANGLE_BITS - 2);

  // Pi/2 in unsigned Q4.60.
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

  typedef logic signed [31:0] elem_t;
  typedef logic signed [63:0] prod_t;
  typedef elem_t row_t [DIM];

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_SCALE  = 3'd1,
    OP_TRANS  = 3'd2,
    OP_ROT_X  = 3'd3,
    OP_ROT_Y  = 3'd4,
    OP_ROT_Z  = 3'd5
  } op_t;

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Quarter-wave sine, round(sin(k*pi/2/QUARTER) * 2^FRACTION_BITS), k = 0..QUARTER.
  // Integer Taylor series in Q60; it is only evaluated at elaboration, where
  // each entry of the sine table becomes a constant.
  function automatic logic [FRACTION_BITS:0] quarter_sin(input logic [ANGLE_BITS-2:0] k);
    logic [63:0] kk, x, x2, term, sum;
    kk   = 64'(k);
    x    = (HALF_PI_Q60 >> (ANGLE_BITS - 2)) * kk
         + (((HALF_PI_Q60 & 64'(QUARTER - 1)) * kk) >> (ANGLE_BITS - 2));
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n < 24; n++) begin
      term = mul_q60(term, x2) / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) != 0) sum = sum - term;
      else              sum = sum + term;
    end
    return (FRACTION_BITS + 1)'((sum + (64'd1 << (59 - FRACTION_BITS))) >> (60 - FRACTION_BITS));
  endfunction

endpackage

/* rtl/tmc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmc_cmd_if / tmc_row_if
// Valid/ready channels for commands and emitted rows.
// ----------------------------------------------------------------------------
interface tmc_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic signed [31:0] value_x;
  logic signed [31:0] value_y;
  logic signed [31:0] value_z;
  logic signed [31:0] value_w;
  logic [11:0]       angle;
  modport source (output valid, op, value_x, value_y, value_z, value_w, angle,
                  input ready);
  modport sink   (input valid, op, value_x, value_y, value_z, value_w, angle,
                  output ready);
endinterface

interface tmc_row_if;
  logic              valid;
  logic              ready;
  logic [1:0]        row_index;
  logic signed [31:0] elem_0;
  logic signed [31:0] elem_1;
  logic signed [31:0] elem_2;
  logic signed [31:0] elem_3;
  logic              last_row;
  modport source (output valid, row_index, elem_0, elem_1, elem_2, elem_3, last_row,
                  input ready);
  modport sink   (input valid, row_index, elem_0, elem_1, elem_2, elem_3, last_row,
                  output ready);
endinterface

/* rtl/tmc_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmc_lane
// One element of a row: four registered products, then sum, shift, saturate.
// ----------------------------------------------------------------------------
module tmc_lane (
  input  logic                clk,
  input  logic                en,
  input  tmc_pkg::row_t       m_row,
  input  tmc_pkg::row_t       t_col,
  output tmc_pkg::elem_t      result
);
  import tmc_pkg::*;

  prod_t               prod_r [DIM];
  logic signed [65:0]  sum;
  logic signed [65:0]  shifted;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIM; k++) prod_r[k] <= m_row[k] * t_col[k];
    end
  end

  always_comb begin
    sum = 66'(prod_r[0]) + 66'(prod_r[1]) + 66'(prod_r[2]) + 66'(prod_r[3]);
    shifted = sum >>> FRACTION_BITS;
    if (shifted > 66'sd2147483647)       result = 32'sh7FFFFFFF;
    else if (shifted < -66'sd2147483648) result = 32'sh80000000;
    else                                 result = shifted[31:0];
  end
endmodule

/* rtl/transform_matrix_composer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transform_matrix_composer
// Holds a 4x4 Q16.16 matrix, right-multiplies it by a built transform per
// request (a load replaces it with a scaled identity) and emits the new
// matrix one row per cycle while the row channel is not stalled. Each row
// passes the registered request, the lane products and the output register.
// The four multiply lanes compute one row per cycle; the next request is taken
// while the last row of the previous one enters the lanes.
// Reset: synchronous active-low; matrix returns to identity, pipeline empties.
// ----------------------------------------------------------------------------
module transform_matrix_composer (
  input logic       clk,
  input logic       rst_n,
  tmc_cmd_if.sink   in_cmd,
  tmc_row_if.source out_row
);
  import tmc_pkg::*;

  localparam elem_t ONE = elem_t'(1 << FRACTION_BITS);

  elem_t      mat_r [DIM][DIM];
  logic       busy_r;
  logic       load_r;
  logic [1:0] row_r;
  // Registered request.
  logic [2:0] op_r;
  elem_t      vx_r, vy_r, vz_r, vw_r;
  logic [FRACTION_BITS:0] s_mag_r, c_mag_r;
  logic       s_neg_r, c_neg_r;
  // Product stage.
  logic       p_vld_r;
  logic       p_load_r;
  logic [1:0] p_row_r;
  row_t       p_mrow_r;
  // Output register.
  logic       o_vld_r;
  logic [1:0] o_row_r;
  elem_t      o_el_r [DIM];

  logic [FRACTION_BITS:0] sin_tab [QUARTER+1];
  logic [ANGLE_BITS-1:0]  c_ang;
  logic [ANGLE_BITS-2:0]  s_idx, c_idx;
  elem_t      s_val, c_val;
  elem_t      tb [DIM][DIM];
  row_t       res;
  row_t       mrow, tcol [DIM];
  logic       adv;

  for (genvar k = 0; k <= QUARTER; k++) begin : g_sin
    localparam logic [FRACTION_BITS:0] SIN_K = quarter_sin((ANGLE_BITS - 1)'(k));
    assign sin_tab[k] = SIN_K;
  end

  assign adv = !o_vld_r || out_row.ready;
  assign in_cmd.ready = adv && (!busy_r || row_r == 2'(DIM - 1));

  // Table addresses: odd quadrants mirror the quarter wave, the upper half
  // negates it. Cosine is the sine a quarter turn ahead.
  always_comb begin
    c_ang = in_cmd.angle + ANGLE_BITS'(QUARTER);
    if (in_cmd.angle[ANGLE_BITS-2])
      s_idx = (ANGLE_BITS - 1)'(QUARTER) - {1'b0, in_cmd.angle[ANGLE_BITS-3:0]};
    else
      s_idx = {1'b0, in_cmd.angle[ANGLE_BITS-3:0]};
    if (c_ang[ANGLE_BITS-2])
      c_idx = (ANGLE_BITS - 1)'(QUARTER) - {1'b0, c_ang[ANGLE_BITS-3:0]};
    else
      c_idx = {1'b0, c_ang[ANGLE_BITS-3:0]};
  end

  always_comb begin
    s_val = s_neg_r ? -$signed(32'(s_mag_r)) : $signed(32'(s_mag_r));
    c_val = c_neg_r ? -$signed(32'(c_mag_r)) : $signed(32'(c_mag_r));
    for (int i = 0; i < DIM; i++)
      for (int j = 0; j < DIM; j++) tb[i][j] = (i == j) ? ONE : '0;
    case (op_r)
      OP_LOAD: begin
        for (int i = 0; i < DIM; i++) tb[i][i] = vx_r;
      end
      OP_SCALE: begin
        tb[0][0] = vx_r; tb[1][1] = vy_r;
        tb[2][2] = vz_r; tb[3][3] = vw_r;
      end
      OP_TRANS: begin
        tb[3][0] = vx_r; tb[3][1] = vy_r;
        tb[3][2] = vz_r; tb[3][3] = vw_r;
      end
      OP_ROT_X: begin
        tb[1][1] = c_val; tb[1][2] = -s_val; tb[2][1] = s_val; tb[2][2] = c_val;
      end
      OP_ROT_Y: begin
        tb[0][0] = c_val; tb[0][2] = s_val; tb[2][0] = -s_val; tb[2][2] = c_val;
      end
      OP_ROT_Z: begin
        tb[0][0] = c_val; tb[0][1] = -s_val; tb[1][0] = s_val; tb[1][1] = c_val;
      end
      default: ;
    endcase
    mrow = mat_r[row_r];
    for (int j = 0; j < DIM; j++)
      for (int k = 0; k < DIM; k++) tcol[j][k] = tb[k][j];
  end

  for (genvar g = 0; g < DIM; g++) begin : g_lane
    tmc_lane u_lane (
      .clk    (clk),
      .en     (adv),
      .m_row  (mrow),
      .t_col  (tcol[g]),
      .result (res[g])
    );
  end

  // Rows are read before written: row i is only overwritten once its own
  // product left the lanes, and later rows do not read earlier ones.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      row_r   <= '0;
      p_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
      for (int i = 0; i < DIM; i++)
        for (int j = 0; j < DIM; j++) mat_r[i][j] <= (i == j) ? ONE : '0;
    end else begin
      if (in_cmd.valid && in_cmd.ready) begin
        busy_r  <= 1'b1;
        load_r  <= (in_cmd.op == OP_LOAD);
        op_r    <= in_cmd.op;
        vx_r    <= in_cmd.value_x;
        vy_r    <= in_cmd.value_y;
        vz_r    <= in_cmd.value_z;
        vw_r    <= in_cmd.value_w;
        s_mag_r <= sin_tab[s_idx];
        s_neg_r <= in_cmd.angle[ANGLE_BITS-1];
        c_mag_r <= sin_tab[c_idx];
        c_neg_r <= c_ang[ANGLE_BITS-1];
      end else if (adv && busy_r && row_r == 2'(DIM - 1)) begin
        busy_r <= 1'b0;
      end
      if (adv) begin
        p_vld_r  <= busy_r;
        p_load_r <= load_r;
        p_row_r  <= row_r;
        p_mrow_r <= tb[row_r];
        // The row counter wraps to zero after the last row.
        if (busy_r) row_r <= row_r + 2'd1;
        o_vld_r <= p_vld_r;
        if (p_vld_r) begin
          o_row_r <= p_row_r;
          for (int j = 0; j < DIM; j++) begin
            o_el_r[j]          <= p_load_r ? p_mrow_r[j] : res[j];
            mat_r[p_row_r][j]  <= p_load_r ? p_mrow_r[j] : res[j];
          end
        end
      end
    end
  end

  assign out_row.valid     = o_vld_r;
  assign out_row.row_index = o_row_r;
  assign out_row.elem_0    = o_el_r[0];
  assign out_row.elem_1    = o_el_r[1];
  assign out_row.elem_2    = o_el_r[2];
  assign out_row.elem_3    = o_el_r[3];
  assign out_row.last_row  = (o_row_r == 2'(DIM - 1));

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && row_r != 2'(DIM - 1)) |-> !in_cmd.ready)
    else $error("request accepted while busy");
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    (p_vld_r && adv && p_row_r != 2'(DIM - 1)) |=> p_vld_r)
    else $error("row sequence broken");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (o_vld_r && !out_row.ready) |=> (o_vld_r && $stable(o_row_r)))
    else $error("output row dropped");
endmodule

/* bench/tmc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmc_checker
// Watches the command and row channels of the matrix composer. It keeps its
// own copy of the held matrix, works out the four rows that each accepted
// request must produce and compares every emitted row field by field.
// ----------------------------------------------------------------------------
module tmc_checker (
  input  logic clk,
  input  logic rst_n,
  tmc_cmd_if   cmd_mon,
  tmc_row_if   row_mon,
  output int   fail_count,
  output int   rows_pending
);
  import tmc_pkg::*;

  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

  typedef struct packed {
    logic [1:0]       idx;
    logic [3:0][31:0] e;
    logic             last;
  } row_exp_t;

  elem_t    held_mat [DIM][DIM];
  row_exp_t rows_expected [$];

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Integer Taylor series of the quarter-wave sine, rounded to FRACTION_BITS.
  function automatic longint quarter_sine(input logic [63:0] k);
    logic [63:0] q, x, x2, term, sum;
    q    = 64'd1 << (ANGLE_BITS - 2);
    x    = (HALF_PI_Q60 / q) * k + ((HALF_PI_Q60 % q) * k) / q;
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n < 24; n++) begin
      term = mul_q60(term, x2) / (64'(2 * n) * 64'(2 * n + 1));
      if (term == 0) break;
      if (n % 2) sum = sum - term;
      else       sum = sum + term;
    end
    return longint'((sum + (64'd1 << (59 - FRACTION_BITS))) >> (60 - FRACTION_BITS));
  endfunction

  function automatic longint sine_of(input logic [ANGLE_BITS-1:0] a);
    logic [1:0]  quad;
    logic [63:0] r;
    quad = a[ANGLE_BITS-1 -: 2];
    r    = 64'(a[ANGLE_BITS-3:0]);
    case (quad)
      2'd0:    return quarter_sine(r);
      2'd1:    return quarter_sine(QUARTER - r);
      2'd2:    return -quarter_sine(r);
      default: return -quarter_sine(QUARTER - r);
    endcase
  endfunction

  // Exact four-term dot product, floor shift, then clamp to 32 bits.
  function automatic elem_t dot_sat(input longint m [DIM], input longint t [DIM]);
    logic signed [127:0] acc, sh;
    acc = '0;
    for (int k = 0; k < DIM; k++) acc = acc + 128'(m[k] * t[k]);
    sh = acc >>> FRACTION_BITS;
    if (sh > 128'sd2147483647)  return 32'h7FFFFFFF;
    if (sh < -128'sd2147483648) return 32'h80000000;
    return sh[31:0];
  endfunction

  task automatic apply_request(input logic [2:0] op, input elem_t vx, input elem_t vy,
                               input elem_t vz, input elem_t vw,
                               input logic [ANGLE_BITS-1:0] ang);
    longint xf [DIM][DIM];
    longint mrow [DIM];
    longint tcol [DIM];
    elem_t  nxt [DIM][DIM];
    longint s, c;
    row_exp_t r;
    s = sine_of(ang);
    c = sine_of(ang + ANGLE_BITS'(QUARTER));
    for (int i = 0; i < DIM; i++)
      for (int j = 0; j < DIM; j++)
        xf[i][j] = (i == j) ? (64'sd1 <<< FRACTION_BITS) : 0;
    case (op)
      OP_SCALE: begin
        xf[0][0] = vx; xf[1][1] = vy; xf[2][2] = vz; xf[3][3] = vw;
      end
      OP_TRANS: begin
        xf[3][0] = vx; xf[3][1] = vy; xf[3][2] = vz; xf[3][3] = vw;
      end
      OP_ROT_X: begin
        xf[1][1] = c; xf[1][2] = -s; xf[2][1] = s; xf[2][2] = c;
      end
      OP_ROT_Y: begin
        xf[0][0] = c; xf[0][2] = s; xf[2][0] = -s; xf[2][2] = c;
      end
      OP_ROT_Z: begin
        xf[0][0] = c; xf[0][1] = -s; xf[1][0] = s; xf[1][1] = c;
      end
      default: ;
    endcase
    if (op == OP_LOAD) begin
      for (int i = 0; i < DIM; i++)
        for (int j = 0; j < DIM; j++)
          held_mat[i][j] = (i == j) ? vx : '0;
    end else if (op <= OP_ROT_Z) begin
      for (int i = 0; i < DIM; i++)
        for (int j = 0; j < DIM; j++) begin
          for (int k = 0; k < DIM; k++) begin
            mrow[k] = held_mat[i][k];
            tcol[k] = xf[k][j];
          end
          nxt[i][j] = dot_sat(mrow, tcol);
        end
      held_mat = nxt;
    end
    // Unused opcodes leave the matrix alone but still emit it.
    for (int i = 0; i < DIM; i++) begin
      r.idx  = 2'(i);
      for (int j = 0; j < DIM; j++) r.e[j] = held_mat[i][j];
      r.last = (i == DIM - 1);
      rows_expected.push_back(r);
    end
  endtask

  task automatic compare_row();
    row_exp_t exp_r;
    logic [31:0] got [DIM];
    got[0] = row_mon.elem_0; got[1] = row_mon.elem_1;
    got[2] = row_mon.elem_2; got[3] = row_mon.elem_3;
    if (rows_expected.size() == 0) begin
      $error("row emitted with no request outstanding: row_index=%0d", row_mon.row_index);
      fail_count++;
      return;
    end
    exp_r = rows_expected.pop_front();
    if (row_mon.row_index !== exp_r.idx) begin
      $error("row_index: expected %0d, got %0d", exp_r.idx, row_mon.row_index);
      fail_count++;
    end
    for (int j = 0; j < DIM; j++)
      if (got[j] !== exp_r.e[j]) begin
        $error("elem_%0d: expected %h, got %h", j, exp_r.e[j], got[j]);
        fail_count++;
      end
    if (row_mon.last_row !== exp_r.last) begin
      $error("last_row: expected %0b, got %0b", exp_r.last, row_mon.last_row);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIM; i++)
        for (int j = 0; j < DIM; j++)
          held_mat[i][j] = (i == j) ? (32'sd1 <<< FRACTION_BITS) : '0;
      rows_expected.delete();
    end else begin
      if (row_mon.valid && row_mon.ready) compare_row();
      if (cmd_mon.valid && cmd_mon.ready)
        apply_request(cmd_mon.op, cmd_mon.value_x, cmd_mon.value_y, cmd_mon.value_z,
                      cmd_mon.value_w, cmd_mon.angle);
    end
    rows_pending = rows_expected.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the matrix composer with directed and random transform requests,
// throttles the row channel at random and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import tmc_pkg::*;

  localparam int RANDOM_ITEMS = 152;
  localparam int IDLE_LIMIT   = 5000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   rows_pending;
  logic cmd_fire;
  int   idle_cycles;
  int   sent;
  bit   hold_done;

  tmc_cmd_if in_cmd ();
  tmc_row_if out_row ();

  transform_matrix_composer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_cmd (in_cmd),
    .out_row(out_row)
  );

  tmc_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_mon     (in_cmd),
    .row_mon     (out_row),
    .fail_count  (fail_count),
    .rows_pending(rows_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Handshakes as seen just before each edge.
  always @(posedge clk) begin
    cmd_fire <= in_cmd.valid && in_cmd.ready;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_cmd.valid && in_cmd.ready) || (out_row.valid && out_row.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 2);
  endfunction

  function automatic elem_t rand_value();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $signed($urandom_range(0, 8 << FRACTION_BITS)) - (4 <<< FRACTION_BITS);
  endfunction

  task automatic send_request(input logic [2:0] op, input elem_t vx, input elem_t vy,
                              input elem_t vz, input elem_t vw, input logic [11:0] ang);
    in_cmd.valid   <= 1'b1;
    in_cmd.op      <= op;
    in_cmd.value_x <= vx;
    in_cmd.value_y <= vy;
    in_cmd.value_z <= vz;
    in_cmd.value_w <= vw;
    in_cmd.angle   <= ang;
    do @(negedge clk); while (!cmd_fire);
    sent++;
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_cmd.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off while requests keep coming.
  initial begin
    int n;
    out_row.ready = 1'b0;
    hold_done = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && sent >= 40) begin
        out_row.ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_done = 1;
      end
      if ($urandom_range(0, 2) == 0) begin
        n = gap_len();
        out_row.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_row.ready <= 1'b1;
    end
  end

  initial begin
    logic [2:0] op;
    in_cmd.valid   = 1'b0;
    in_cmd.op      = OP_LOAD;
    in_cmd.value_x = '0;
    in_cmd.value_y = '0;
    in_cmd.value_z = '0;
    in_cmd.value_w = '0;
    in_cmd.angle   = '0;
    sent  = 0;
    rst_n = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: each op, quadrant angles, unused opcodes and saturation.
    send_request(OP_ROT_X, 0, 0, 0, 0, 12'd0);
    send_request(OP_ROT_X, 0, 0, 0, 0, 12'd1024);
    send_request(OP_ROT_Y, 0, 0, 0, 0, 12'd2048);
    send_request(OP_ROT_Z, 0, 0, 0, 0, 12'd3072);
    send_request(OP_ROT_Z, 0, 0, 0, 0, 12'd4095);
    send_request(OP_ROT_Y, 0, 0, 0, 0, 12'd1);
    send_request(OP_TRANS, 32'sd65536, -32'sd131072, 32'sd98304, 32'sd65536, 12'd0);
    send_request(OP_SCALE, 32'sd131072, 32'sd32768, -32'sd65536, 32'sd65536, 12'hFFF);
    send_request(3'd6, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 0, 12'hFFF);
    send_request(3'd7, 0, 0, 0, 0, 12'd0);
    send_request(OP_LOAD, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 12'hABC);
    send_request(OP_SCALE, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 12'd0);
    send_request(OP_TRANS, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 12'd0);
    send_request(OP_LOAD, 32'h80000000, 0, 0, 0, 12'd0);
    send_request(OP_ROT_X, 0, 0, 0, 0, 12'd512);
    send_request(OP_LOAD, -32'sd1, 0, 0, 0, 12'd0);
    send_request(OP_SCALE, -32'sd1, 32'sd1, 32'hFFFFFFFF, 0, 12'd0);
    send_request(OP_LOAD, 32'sd65536, 0, 0, 0, 12'd0);

    // Let everything drain before the random part.
    in_cmd.valid <= 1'b0;
    while (rows_pending != 0) @(negedge clk);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 8 == 0) op = OP_LOAD;
      else if ($urandom_range(0, 29) == 0) op = 3'($urandom_range(6, 7));
      else op = 3'($urandom_range(OP_SCALE, OP_ROT_Z));
      if (op == OP_LOAD && $urandom_range(0, 3) != 0)
        send_request(op, 32'sd65536, $urandom, $urandom, $urandom, 12'($urandom));
      else
        send_request(op, rand_value(), rand_value(), rand_value(), rand_value(),
                     12'($urandom));
      idle_gap(gap_len());
    end
    in_cmd.valid <= 1'b0;

    while (rows_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/tmc_pkg.sv
rtl/tmc_if.sv
rtl/tmc_lane.sv
rtl/transform_matrix_composer.sv
bench/tmc_checker.sv
bench/tb_top.sv
